// File: src/erbc_pkg.sv
package erbc_pkg;

  localparam int LIMIT_BITS = 24;
  localparam int CFG_W      = 24;
  localparam int LIM_W      = (LIMIT_BITS < CFG_W) ? LIMIT_BITS : CFG_W;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] ESC_BYTE  = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] MAX_RUN   = 8'd255;

  localparam logic [1:0] MODE_ENCODE = 2'd0;
  localparam logic [1:0] MODE_DECODE = 2'd1;
  localparam logic [1:0] MODE_LEGACY = 2'd2;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TRUNC = 2'd1;
  localparam logic [1:0] ERR_LIMIT = 2'd2;

  typedef enum logic {
    OP_RUN,
    OP_ITEM
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
    logic [7:0] count;
    logic [1:0] err;
    logic       last;
  } op_t;

  typedef struct packed {
    logic [1:0] n;
    op_t        op0;
    op_t        op1;
  } push_t;

  function automatic op_t mk_item(input logic [7:0] value, input logic [7:0] count,
                                  input logic [1:0] err);
    op_t o;
    o.kind  = OP_ITEM;
    o.value = value;
    o.count = count;
    o.err   = err;
    o.last  = 1'b0;
    return o;
  endfunction

  function automatic op_t mk_run(input logic [7:0] value, input logic [7:0] count);
    op_t o;
    o.kind  = OP_RUN;
    o.value = value;
    o.count = count;
    o.err   = ERR_NONE;
    o.last  = 1'b0;
    return o;
  endfunction

endpackage

// File: src/erbc_front.sv
module erbc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [erbc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        accept,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output erbc_pkg::push_t             push_req
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ESC  = 3'b010,
    PH_CNT  = 3'b100
  } phase_t;

  localparam int LW = erbc_pkg::LIM_W;

  logic [1:0]    mode_r;
  logic [LW-1:0] limit_r;
  logic [7:0]    held_value_r, held_value_nxt;
  logic [7:0]    run_length_r, run_length_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    held_count_r, held_count_nxt;
  logic [LW-1:0] produced_r, produced_nxt;
  logic          err_r, err_nxt;

  erbc_pkg::op_t slot [2];
  logic [1:0]    n;
  logic          legacy;
  logic          do1, do2, ovf1, ovf2, flush_a;
  logic [7:0]    v1, c1;
  logic [LW:0]   sum1, sum2;

  always_comb begin
    held_value_nxt = held_value_r;
    run_length_nxt = run_length_r;
    phase_nxt      = phase_r;
    held_count_nxt = held_count_r;
    produced_nxt   = produced_r;
    err_nxt        = err_r;
    slot[0]        = erbc_pkg::mk_item(erbc_pkg::ZERO_BYTE, 8'd0, erbc_pkg::ERR_NONE);
    slot[1]        = erbc_pkg::mk_item(erbc_pkg::ZERO_BYTE, 8'd0, erbc_pkg::ERR_NONE);
    n              = 2'd0;
    legacy         = (mode_r == erbc_pkg::MODE_LEGACY);
    do1            = 1'b0;
    do2            = 1'b0;
    v1             = in_byte;
    c1             = 8'd1;
    flush_a        = 1'b0;

    if (mode_r == erbc_pkg::MODE_ENCODE) begin
      flush_a = (run_length_r != 8'd0) &&
                ((in_byte != held_value_r) || (run_length_r == erbc_pkg::MAX_RUN));
      if (flush_a) begin
        slot[0] = erbc_pkg::mk_run(held_value_r, run_length_r);
        n       = 2'd1;
      end
      if (flush_a || (run_length_r == 8'd0)) begin
        held_value_nxt = in_byte;
        run_length_nxt = 8'd1;
      end else begin
        run_length_nxt = run_length_r + 8'd1;
      end
      if (in_last) begin
        slot[n[0]] = erbc_pkg::mk_run(held_value_nxt, run_length_nxt);
        n          = n + 2'd1;
      end
    end else if (err_r) begin
      if (in_last) begin
        slot[0] = erbc_pkg::mk_item(erbc_pkg::ZERO_BYTE, 8'd0, erbc_pkg::ERR_NONE);
        n       = 2'd1;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if ((in_byte == erbc_pkg::ESC_BYTE) && !(legacy && in_last)) begin
            phase_nxt = PH_ESC;
          end else begin
            do1 = 1'b1;
          end
        end
        PH_ESC: begin
          if (!legacy && (in_byte == erbc_pkg::ZERO_BYTE)) begin
            phase_nxt = PH_IDLE;
            do1       = 1'b1;
            v1        = erbc_pkg::ESC_BYTE;
          end else if (legacy && in_last) begin
            phase_nxt = PH_IDLE;
            do1       = 1'b1;
            do2       = 1'b1;
            v1        = erbc_pkg::ESC_BYTE;
          end else begin
            held_count_nxt = in_byte;
            phase_nxt      = PH_CNT;
          end
        end
        PH_CNT: begin
          phase_nxt = PH_IDLE;
          do1       = 1'b1;
          c1        = held_count_r;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    sum1 = {1'b0, produced_r} + {{(LW-7){1'b0}}, c1};
    sum2 = {1'b0, produced_r} + (LW+1)'(2);
    ovf1 = sum1 > {1'b0, limit_r};
    ovf2 = sum2 > {1'b0, limit_r};

    if (mode_r != erbc_pkg::MODE_ENCODE && !err_r) begin
      if (do1) begin
        if (ovf1) begin
          slot[n[0]] = erbc_pkg::mk_item(erbc_pkg::ZERO_BYTE, 8'd0, erbc_pkg::ERR_LIMIT);
          n          = n + 2'd1;
          err_nxt    = 1'b1;
        end else begin
          produced_nxt = sum1[LW-1:0];
          if (c1 != 8'd0) begin
            slot[n[0]] = erbc_pkg::mk_item(v1, c1, erbc_pkg::ERR_NONE);
            n          = n + 2'd1;
          end
        end
      end
      if (do2 && !ovf1) begin
        if (ovf2) begin
          slot[n[0]] = erbc_pkg::mk_item(erbc_pkg::ZERO_BYTE, 8'd0, erbc_pkg::ERR_LIMIT);
          err_nxt    = 1'b1;
        end else begin
          produced_nxt = sum2[LW-1:0];
          slot[n[0]]   = erbc_pkg::mk_item(in_byte, 8'd1, erbc_pkg::ERR_NONE);
        end
        n = n + 2'd1;
      end
      if (in_last && !err_nxt && (phase_nxt != PH_IDLE)) begin
        slot[n[0]] = erbc_pkg::mk_item(erbc_pkg::ZERO_BYTE, 8'd0, erbc_pkg::ERR_TRUNC);
        n          = n + 2'd1;
      end
      if (in_last && (n == 2'd0)) begin
        slot[0] = erbc_pkg::mk_item(erbc_pkg::ZERO_BYTE, 8'd0, erbc_pkg::ERR_NONE);
        n       = 2'd1;
      end
    end

    if (in_last && (n != 2'd0)) begin
      slot[n[1]].last = 1'b1;
    end

    if (in_last) begin
      held_value_nxt = 8'd0;
      run_length_nxt = 8'd0;
      phase_nxt      = PH_IDLE;
      held_count_nxt = 8'd0;
      produced_nxt   = '0;
      err_nxt        = 1'b0;
    end

    push_req.n   = accept ? n : 2'd0;
    push_req.op0 = slot[0];
    push_req.op1 = slot[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= erbc_pkg::MODE_ENCODE;
      limit_r      <= '1;
      held_value_r <= 8'd0;
      run_length_r <= 8'd0;
      phase_r      <= PH_IDLE;
      held_count_r <= 8'd0;
      produced_r   <= '0;
      err_r        <= 1'b0;
    end else if (cfg_we && (cfg_index == erbc_pkg::REG_MODE)) begin
      mode_r       <= cfg_data[1:0];
      held_value_r <= 8'd0;
      run_length_r <= 8'd0;
      phase_r      <= PH_IDLE;
      held_count_r <= 8'd0;
      produced_r   <= '0;
      err_r        <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == erbc_pkg::REG_LIMIT)) begin
        limit_r <= cfg_data[LW-1:0];
      end
      if (accept) begin
        held_value_r <= held_value_nxt;
        run_length_r <= run_length_nxt;
        phase_r      <= phase_nxt;
        held_count_r <= held_count_nxt;
        produced_r   <= produced_nxt;
        err_r        <= err_nxt;
      end
    end
  end

endmodule

// File: src/erbc_queue.sv
module erbc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  erbc_pkg::push_t push_req,
  output logic            no_room,
  input  logic            rd_en,
  output logic            rd_valid,
  output erbc_pkg::op_t   rd_op
);

  localparam int AW = erbc_pkg::QAW;

  erbc_pkg::op_t q_r [erbc_pkg::QDEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          rd_fire;

  // room for two ops is required before taking a transaction
  assign no_room  = cnt_r > (AW+1)'(erbc_pkg::QDEPTH - 2);
  assign rd_valid = cnt_r != '0;
  assign rd_op    = q_r[head_r];
  assign rd_fire  = rd_en && rd_valid;

  always_comb begin
    head_nxt = rd_fire ? head_r + AW'(1) : head_r;
    tail_nxt = tail_r + AW'(push_req.n);
    cnt_nxt  = cnt_r + (AW+1)'(push_req.n) - (AW+1)'(rd_fire);
  end

  always_ff @(posedge clk) begin
    if (push_req.n != 2'd0) begin
      q_r[tail_r] <= push_req.op0;
    end
    if (push_req.n == 2'd2) begin
      q_r[tail_r + AW'(1)] <= push_req.op1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: src/erbc_back.sv
module erbc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  erbc_pkg::op_t q_op,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic [7:0]    out_repeat,
  output logic          out_last,
  output logic [1:0]    out_error
);

  erbc_pkg::op_t cur_r;
  logic          cur_valid_r, cur_valid_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    byte_r, rep_r;
  logic          last_r;
  logic [1:0]    err_r;

  logic [2:0]    nsteps;
  logic          final_step, adv, cur_take, is_triple;
  logic [7:0]    res_byte, res_rep;
  logic [1:0]    res_err;

  always_comb begin
    is_triple = |cur_r.count[7:2];
    if (cur_r.kind == erbc_pkg::OP_ITEM) begin
      nsteps = 3'd1;
    end else if (is_triple) begin
      nsteps = 3'd3;
    end else if (cur_r.value == erbc_pkg::ESC_BYTE) begin
      nsteps = {cur_r.count[1:0], 1'b0};
    end else begin
      nsteps = {1'b0, cur_r.count[1:0]};
    end
    final_step = step_r == (nsteps - 3'd1);

    res_rep = 8'd1;
    res_err = erbc_pkg::ERR_NONE;
    if (cur_r.kind == erbc_pkg::OP_ITEM) begin
      res_byte = cur_r.value;
      res_rep  = cur_r.count;
      res_err  = cur_r.err;
    end else if (is_triple) begin
      priority if (step_r == 3'd0) begin
        res_byte = erbc_pkg::ESC_BYTE;
      end else if (step_r == 3'd1) begin
        res_byte = cur_r.count;
      end else begin
        res_byte = cur_r.value;
      end
    end else if (cur_r.value == erbc_pkg::ESC_BYTE) begin
      res_byte = step_r[0] ? erbc_pkg::ZERO_BYTE : erbc_pkg::ESC_BYTE;
    end else begin
      res_byte = cur_r.value;
    end

    adv           = cur_valid_r && (!out_valid_r || pop);
    cur_take      = !cur_valid_r || (adv && final_step);
    q_pop         = cur_take && q_valid;
    cur_valid_nxt = cur_take ? q_valid : cur_valid_r;
    step_nxt      = cur_take ? 3'd0 : (adv ? step_r + 3'd1 : step_r);
    out_valid_nxt = adv ? 1'b1 : (pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_op;
    end
    if (adv) begin
      byte_r <= res_byte;
      rep_r  <= res_rep;
      err_r  <= res_err;
      last_r <= cur_r.last && final_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty      = !out_valid_r;
  assign out_byte   = byte_r;
  assign out_repeat = rep_r;
  assign out_last   = last_r;
  assign out_error  = err_r;

endmodule

// File: src/escaped_rle_byte_codec_unit.sv
// Escaped run-length byte codec (0xFF marker): encodes, or decodes in current or legacy format,
// one byte per input transaction. A byte is taken in the cycle it is pushed whenever the
// internal four-entry op queue has room for two ops, so bytes may arrive back to back; each byte
// is turned into at most two ops, and the output side expands those into results at one per
// cycle while results are popped (an encoder run of three literal 0xFF bytes gives six
// results). The sustained rate is therefore set by the result expander. A byte's ops pass
// through the op queue and the current-op register of the expander before its first result
// is registered at the output. Write configuration only while no transaction is in flight;
// writing codec_mode drops any partial frame.
module escaped_rle_byte_codec_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [erbc_pkg::CFG_W-1:0] cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 in_byte,
  input  logic                       in_last,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 out_byte,
  output logic [7:0]                 out_repeat,
  output logic                       out_last,
  output logic [1:0]                 out_error
);

  erbc_pkg::push_t push_req;
  erbc_pkg::op_t   q_op;
  logic            q_valid, q_pop, accept;

  assign accept = push && !full;

  erbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .push_req (push_req)
  );

  erbc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_req(push_req),
    .no_room (full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_op   (q_op)
  );

  erbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_repeat(out_repeat),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule
